/* rtl/gorf_pkg.sv */
// Shared types, constants and the CRC-32 byte step for the output report framer.
// No dependencies; imported by every module of the framer.
package gorf_pkg;

    // Report geometry: 79 report bytes plus one zero pad byte fill ten 8-byte words
    localparam int unsigned IDX_W        = 7;
    localparam logic [IDX_W-1:0] CRC_SPAN   = 7'd75;
    localparam logic [IDX_W-1:0] LAST_INDEX = 7'd79;
    localparam logic [2:0]       WORD_LAST_LANE = 3'd7;

    localparam logic [3:0] COUNT_FULL  = 4'd8;
    localparam logic [3:0] COUNT_FINAL = 4'd7;

    // Byte offsets within the report
    localparam logic [IDX_W-1:0] OFS_HDR0   = 7'd0;
    localparam logic [IDX_W-1:0] OFS_HDR1   = 7'd1;
    localparam logic [IDX_W-1:0] OFS_SEQ    = 7'd2;
    localparam logic [IDX_W-1:0] OFS_TAG    = 7'd3;
    localparam logic [IDX_W-1:0] OFS_FLAG0  = 7'd4;
    localparam logic [IDX_W-1:0] OFS_FLAG1  = 7'd5;
    localparam logic [IDX_W-1:0] OFS_MOTR   = 7'd6;
    localparam logic [IDX_W-1:0] OFS_MOTL   = 7'd7;
    localparam logic [IDX_W-1:0] OFS_MUTE   = 7'd12;
    localparam logic [IDX_W-1:0] OFS_LEDEN0 = 7'd42;
    localparam logic [IDX_W-1:0] OFS_LEDEN1 = 7'd45;
    localparam logic [IDX_W-1:0] OFS_BRIGHT = 7'd46;
    localparam logic [IDX_W-1:0] OFS_PLAYER = 7'd47;
    localparam logic [IDX_W-1:0] OFS_RED    = 7'd48;
    localparam logic [IDX_W-1:0] OFS_GREEN  = 7'd49;
    localparam logic [IDX_W-1:0] OFS_BLUE   = 7'd50;

    // Fixed byte values
    localparam logic [7:0] HDR0_VAL   = 8'hA2;
    localparam logic [7:0] HDR1_VAL   = 8'h31;
    localparam logic [7:0] TAG_VAL    = 8'h10;
    localparam logic [7:0] FLAG0_VAL  = 8'h03;
    localparam logic [7:0] FLAG1_VAL  = 8'h15;
    localparam logic [7:0] LEDEN_VAL  = 8'h02;
    localparam logic [7:0] BRIGHT_VAL = 8'h01;
    localparam logic [4:0] PLAYER_MASK = 5'h1F;

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // CRC unit control, driven by the sequencer
    typedef struct packed {
        logic feed;   // fold one report byte into the CRC
        logic shift;  // shift the finished CRC out one byte
        logic init;   // reload the seed for the next report
    } crc_ctl_t;

    // One byte of reflected CRC-32
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/gamepad_output_report_framer_unit.sv */
// Top level of the output report framer: command capture, byte sequencer, report byte map.
// Depends on gorf_pkg, gorf_crc and gorf_packer.
//
// Each accepted command produces one 79-byte output report as ten 64-bit words, earliest
// byte in bits 7:0, the tenth word carrying 7 bytes and last. The report is built one byte
// per clock unless a stalled word holds the sequencer at a word boundary: a byte sequencer
// walks the 80 byte slots (79 report bytes and a zero pad), feeding a byte-serial CRC-32
// and a byte-wide word shift register. The next command is taken the cycle after the pad
// byte has been packed, so no new command is accepted while a report is being built. The
// final word may still wait in the output register when the next command is taken. The
// 4-bit sequence tag in byte 2 advances by one per report and wraps.
module gamepad_output_report_framer_unit
    import gorf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rumble_hi,
    input  logic [7:0]  rumble_lo,
    input  logic [7:0]  mute_led,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  led_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data_word,
    output logic [3:0]  byte_count,
    output logic        last
);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [3:0]       seq_reg;
    logic [3:0]       seq_next;
    logic [7:0]       rumble_hi_reg;
    logic [7:0]       rumble_lo_reg;
    logic [7:0]       mute_led_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic [4:0]       player_reg;

    logic       accept;
    logic       advance;
    logic       out_free;
    logic       at_end;
    logic [7:0] crc_byte;
    logic [7:0] cur_byte;
    crc_ctl_t   crc_ctl;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign at_end   = (idx_reg == LAST_INDEX);
    // Hold at a word boundary while the previous word still waits
    assign advance  = busy_reg && ((idx_reg[2:0] != WORD_LAST_LANE) || out_free);

    // Sequencer
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        seq_next  = seq_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (advance)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
                seq_next  = seq_reg + 4'd1;
            end
            else
            begin
                idx_next = idx_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            seq_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            seq_reg  <= seq_next;
        end
    end

    // Command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rumble_hi_reg <= rumble_hi;
            rumble_lo_reg <= rumble_lo;
            mute_led_reg  <= mute_led;
            red_reg       <= red;
            green_reg     <= green;
            blue_reg      <= blue;
            player_reg    <= led_mask[4:0] & PLAYER_MASK;
        end
    end

    // Report byte map; CRC trailer comes from the CRC unit
    always_comb
    begin
        cur_byte = 8'd0;
        if (idx_reg >= CRC_SPAN && !at_end)
        begin
            cur_byte = crc_byte;
        end
        else
        begin
            unique case (idx_reg)
                OFS_HDR0:   cur_byte = HDR0_VAL;
                OFS_HDR1:   cur_byte = HDR1_VAL;
                OFS_SEQ:    cur_byte = {seq_reg, 4'd0};
                OFS_TAG:    cur_byte = TAG_VAL;
                OFS_FLAG0:  cur_byte = FLAG0_VAL;
                OFS_FLAG1:  cur_byte = FLAG1_VAL;
                OFS_MOTR:   cur_byte = rumble_hi_reg;
                OFS_MOTL:   cur_byte = rumble_lo_reg;
                OFS_MUTE:   cur_byte = mute_led_reg;
                OFS_LEDEN0: cur_byte = LEDEN_VAL;
                OFS_LEDEN1: cur_byte = LEDEN_VAL;
                OFS_BRIGHT: cur_byte = BRIGHT_VAL;
                OFS_PLAYER: cur_byte = {3'd0, player_reg};
                OFS_RED:    cur_byte = red_reg;
                OFS_GREEN:  cur_byte = green_reg;
                OFS_BLUE:   cur_byte = blue_reg;
                default:    cur_byte = 8'd0;
            endcase
        end
    end

    // CRC control: fold bytes 0..74, shift out 75..78, reseed on the pad slot
    always_comb
    begin
        crc_ctl.feed  = advance && (idx_reg < CRC_SPAN);
        crc_ctl.shift = advance && (idx_reg >= CRC_SPAN) && !at_end;
        crc_ctl.init  = advance && at_end;
    end

    gorf_crc u_crc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (crc_ctl),
        .data_in  (cur_byte),
        .crc_byte (crc_byte)
    );

    gorf_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .byte_in    (cur_byte),
        .word_done  (idx_reg[2:0] == WORD_LAST_LANE),
        .final_word (at_end),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last)
    );

endmodule

/* rtl/gorf_crc.sv */
// Byte-serial CRC-32 unit: accumulates report bytes, then shifts the result out.
// Depends on gorf_pkg.
module gorf_crc
    import gorf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  crc_ctl_t   ctl,
    input  logic [7:0] data_in,
    output logic [7:0] crc_byte
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    // Accumulate, shift out, or reseed
    always_comb
    begin
        crc_next = crc_reg;
        priority if (ctl.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.feed)
        begin
            crc_next = crc_step(crc_reg, data_in);
        end
        else if (ctl.shift)
        begin
            crc_next = {8'd0, crc_reg[31:8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    // Final xor applied on the way out, low byte first
    assign crc_byte = ~crc_reg[7:0];

endmodule

/* rtl/gorf_packer.sv */
// Byte-to-word packer: shifts bytes into a 64-bit word and holds finished words for output.
// Depends on gorf_pkg.
module gorf_packer
    import gorf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  byte_in,
    input  logic        word_done,
    input  logic        final_word,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] data_word,
    output logic [3:0]  byte_count,
    output logic        last
);

    logic [63:0] shift_reg;
    logic [63:0] shift_next;
    logic        valid_reg;
    logic        valid_next;
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        last_reg;
    logic        load;

    assign out_free   = !valid_reg || !out_stall;
    assign load       = advance && word_done;
    // Earliest byte ends up in bits 7:0 after eight shifts
    assign shift_next = {byte_in, shift_reg[63:8]};

    // Output holding register
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shift_reg <= shift_next;
        end
        if (load)
        begin
            word_reg  <= shift_next;
            count_reg <= final_word ? COUNT_FINAL : COUNT_FULL;
            last_reg  <= final_word;
        end
    end

    assign out_valid  = valid_reg;
    assign data_word  = word_reg;
    assign byte_count = count_reg;
    assign last       = last_reg;

endmodule
